>>> rtl/rrtt_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin thread table package
// Field widths, command, slot state and status codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rrtt_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned THREAD_W  = 6;
  localparam int unsigned OWNER_W   = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SLOT_ST_W = 2;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [THREAD_W-1:0]  thread_t;
  typedef logic [OWNER_W-1:0]   owner_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [SLOT_ST_W-1:0] slot_st_t;
  typedef logic [1:0]           kind_t;

  localparam cmd_t CMD_CREATE    = 3'd0;
  localparam cmd_t CMD_TERMINATE = 3'd1;
  localparam cmd_t CMD_BLOCK     = 3'd2;
  localparam cmd_t CMD_UNBLOCK   = 3'd3;
  localparam cmd_t CMD_TERM_ALL  = 3'd4;
  localparam cmd_t CMD_SCHEDULE  = 3'd5;

  localparam slot_st_t SLOT_READY      = 2'd0;
  localparam slot_st_t SLOT_RUNNING    = 2'd1;
  localparam slot_st_t SLOT_BLOCKED    = 2'd2;
  localparam slot_st_t SLOT_TERMINATED = 2'd3;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_NO_THREAD = 2'd1;
  localparam status_t STATUS_FULL      = 2'd2;
  localparam status_t STATUS_IDLE      = 2'd3;

  // How an accepted command proceeds after the accept cycle.
  localparam kind_t KIND_DONE   = 2'd0;
  localparam kind_t KIND_SINGLE = 2'd1;
  localparam kind_t KIND_SWEEP  = 2'd2;

  typedef struct packed {
    logic take;
    logic upd;
    logic run;
    logic adjust;
    logic pick;
    logic pick_end;
    logic respond;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  is_sched;
    logic  sweep_done;
    logic  none_ready;
    logic  out_busy;
  } dp_sts_t;

endpackage

>>> rtl/rrtt_if.sv
// ----------------------------------------------------------------------------
// Round-robin thread table channels
// Command channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface rrtt_req_if import rrtt_pkg::*; ();
  logic    valid;
  logic    ready;
  cmd_t    command;
  thread_t thread_id;
  owner_t  owner_id;

  modport source (output valid, output command, output thread_id, output owner_id,
                  input ready);
  modport sink   (input valid, input command, input thread_id, input owner_id,
                  output ready);
endinterface

interface rrtt_rsp_if import rrtt_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  thread_t result_thread;

  modport source (output valid, output status, output result_thread, input ready);
  modport sink   (input valid, input status, input result_thread, output ready);
endinterface

>>> rtl/rrtt_ctrl.sv
// ----------------------------------------------------------------------------
// Round-robin thread table controller
// Sequences accept, single-slot update, table sweeps and the result beat.
// ----------------------------------------------------------------------------
module rrtt_ctrl import rrtt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_ADJ   = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          unique case (sts_i.kind)
            KIND_SINGLE: state_d = S_UPD;
            KIND_SWEEP:  state_d = S_SWEEP;
            default:     state_d = S_RESP;
          endcase
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_RESP;
      end
      S_SWEEP: begin
        cmd_o.run = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = sts_i.is_sched ? S_ADJ : S_RESP;
        end
      end
      S_ADJ: begin
        cmd_o.adjust = 1'b1;
        state_d      = sts_i.none_ready ? S_RESP : S_PICK;
      end
      S_PICK: begin
        cmd_o.run  = 1'b1;
        cmd_o.pick = 1'b1;
        if (sts_i.sweep_done) begin
          cmd_o.pick_end = 1'b1;
          state_d        = S_RESP;
        end
      end
      S_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/rrtt_dp.sv
// ----------------------------------------------------------------------------
// Round-robin thread table datapath
// Slot state and owner memories, sweep pipeline, counters and result register.
// ----------------------------------------------------------------------------
module rrtt_dp import rrtt_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    command_i,
  input  thread_t thread_id_i,
  input  owner_t  owner_id_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output status_t out_status_o,
  output thread_t out_thread_o,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o
);

  localparam int unsigned IW = $clog2(TABLE_SLOTS);
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned MW = (CW > THREAD_W) ? CW : THREAD_W;

  slot_st_t state_mem [TABLE_SLOTS];
  owner_t   owner_mem [TABLE_SLOTS];
  slot_st_t rd_state_q;
  owner_t   rd_owner_q;

  logic [CW-1:0] used_q, rd_idx_q, cnt_q, seen_q;
  logic [IW-1:0] ptr_q, sidx_q, wb_idx_q, chosen_q;
  logic          wb_vld_q, found_q, out_valid_q;
  cmd_t          cmd_q;
  owner_t        owner_q;
  status_t       resp_status_q, out_status_q;
  thread_t       resp_thread_q, out_thread_q;

  logic [MW-1:0] tid_ext, tid_m1;
  logic          id_found, full, rd_avail, rd_run, rd_en, we, owner_we;
  logic [IW-1:0] rd_addr, waddr;
  slot_st_t      wdata;
  kind_t         kind;
  logic [CW-1:0] used_inc, ptr_ext, ptr_inc, chosen_inc;
  logic          mode_all, st_ready, st_live, pick_hit;

  assign tid_ext    = MW'(thread_id_i);
  assign tid_m1     = tid_ext - MW'(1);
  assign id_found   = (tid_ext != '0) && (tid_ext <= MW'(used_q));
  assign full       = (used_q == CW'(TABLE_SLOTS));
  assign used_inc   = used_q + CW'(1);
  assign ptr_ext    = CW'(ptr_q);
  assign ptr_inc    = ptr_ext + CW'(1);
  assign chosen_inc = CW'(chosen_q) + CW'(1);
  assign rd_avail   = (rd_idx_q < used_q);
  assign rd_run     = cmd_i.run && rd_avail;
  assign mode_all   = (cmd_q == CMD_TERM_ALL);
  assign st_ready   = (rd_state_q == SLOT_READY);
  assign st_live    = st_ready || (rd_state_q == SLOT_RUNNING);
  assign pick_hit   = st_ready && (seen_q == ptr_ext) && !found_q;

  always_comb begin
    case (command_i) inside
      CMD_TERMINATE, CMD_BLOCK, CMD_UNBLOCK: kind = id_found ? KIND_SINGLE : KIND_DONE;
      CMD_TERM_ALL, CMD_SCHEDULE:            kind = KIND_SWEEP;
      default:                               kind = KIND_DONE;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_idx_q[IW-1:0];
    if (cmd_i.take && (kind == KIND_SINGLE)) begin
      rd_en   = 1'b1;
      rd_addr = tid_m1[IW-1:0];
    end else if (rd_run) begin
      rd_en = 1'b1;
    end
  end

  // One write port, shared by create, the single-slot update and the sweeps.
  always_comb begin
    we       = 1'b0;
    owner_we = 1'b0;
    waddr    = wb_idx_q;
    wdata    = SLOT_READY;
    if (cmd_i.take && (command_i == CMD_CREATE) && !full) begin
      we       = 1'b1;
      owner_we = 1'b1;
      waddr    = used_q[IW-1:0];
    end else if (cmd_i.upd) begin
      we    = 1'b1;
      waddr = sidx_q;
      wdata = rd_state_q;
      case (cmd_q)
        CMD_TERMINATE: wdata = SLOT_TERMINATED;
        CMD_BLOCK:     if (st_live) wdata = SLOT_BLOCKED;
        CMD_UNBLOCK:   if (rd_state_q == SLOT_BLOCKED) wdata = SLOT_READY;
        default:       wdata = rd_state_q;
      endcase
    end else if (cmd_i.run && wb_vld_q) begin
      if (mode_all) begin
        we    = (rd_owner_q == owner_q);
        wdata = SLOT_TERMINATED;
      end else if (cmd_i.pick) begin
        we    = pick_hit;
        wdata = SLOT_RUNNING;
      end else begin
        we    = (rd_state_q == SLOT_RUNNING);
        wdata = SLOT_READY;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      state_mem[waddr] <= wdata;
    end
    if (owner_we) begin
      owner_mem[waddr] <= owner_id_i;
    end
    if (rd_en) begin
      rd_state_q <= state_mem[rd_addr];
      rd_owner_q <= owner_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      ptr_q       <= '0;
      rd_idx_q    <= '0;
      cnt_q       <= '0;
      seen_q      <= '0;
      wb_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        rd_idx_q <= '0;
        cnt_q    <= '0;
        wb_vld_q <= 1'b0;
        if ((command_i == CMD_CREATE) && !full) begin
          used_q <= used_inc;
        end
      end
      if (cmd_i.run) begin
        wb_vld_q <= rd_run;
        if (rd_run) begin
          rd_idx_q <= rd_idx_q + CW'(1);
        end
        if (wb_vld_q && !mode_all) begin
          if (cmd_i.pick) begin
            if (st_ready) begin
              seen_q <= seen_q + CW'(1);
            end
            if (pick_hit) begin
              found_q <= 1'b1;
            end
          end else if (st_live) begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
      end
      if (cmd_i.adjust) begin
        rd_idx_q <= '0;
        wb_vld_q <= 1'b0;
        seen_q   <= '0;
        found_q  <= 1'b0;
        if ((cnt_q != '0) && (ptr_ext >= cnt_q)) begin
          ptr_q <= '0;
        end
      end
      if (cmd_i.pick_end) begin
        ptr_q <= (ptr_inc == cnt_q) ? '0 : ptr_inc[IW-1:0];
      end
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cmd_q   <= command_i;
      owner_q <= owner_id_i;
      sidx_q  <= tid_m1[IW-1:0];
      case (command_i) inside
        CMD_CREATE: begin
          resp_status_q <= full ? STATUS_FULL : STATUS_OK;
          resp_thread_q <= full ? '0 : THREAD_W'(used_inc);
        end
        CMD_TERMINATE, CMD_BLOCK, CMD_UNBLOCK: begin
          resp_status_q <= id_found ? STATUS_OK : STATUS_NO_THREAD;
          resp_thread_q <= '0;
        end
        default: begin
          resp_status_q <= STATUS_OK;
          resp_thread_q <= '0;
        end
      endcase
    end
    if (cmd_i.run) begin
      wb_idx_q <= rd_idx_q[IW-1:0];
      if (wb_vld_q && cmd_i.pick && pick_hit) begin
        chosen_q <= wb_idx_q;
      end
    end
    if (cmd_i.adjust && (cnt_q == '0)) begin
      resp_status_q <= STATUS_IDLE;
      resp_thread_q <= '0;
    end
    if (cmd_i.pick_end) begin
      resp_status_q <= STATUS_OK;
      resp_thread_q <= THREAD_W'(chosen_inc);
    end
    if (cmd_i.respond) begin
      out_status_q <= resp_status_q;
      out_thread_q <= resp_thread_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_thread_o = out_thread_q;

  assign sts_o.kind       = kind;
  assign sts_o.is_sched   = (cmd_q == CMD_SCHEDULE);
  assign sts_o.sweep_done = !rd_avail && !wb_vld_q;
  assign sts_o.none_ready = (cnt_q == '0);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

>>> rtl/round_robin_thread_table_top.sv
// ----------------------------------------------------------------------------
// Round-robin thread table
// Create needs only the accept and the result beat; terminate, block and unblock
// add a single-slot update; terminate-all sweeps the slots in use once and
// schedule twice, one slot per cycle through one read port.
// One command at a time; the next is accepted once the result is registered.
// Reset clears the slot count, rotation pointer and control; the tables are
// not cleared, since only slots below the count are ever read.
// ----------------------------------------------------------------------------
module round_robin_thread_table_top import rrtt_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rrtt_req_if.sink          req_i,
  rrtt_rsp_if.source        rsp_o
);

  // The controller walks each command through its phases; the datapath
  // holds the tables and does the per-slot work that each phase asks for.
  // A schedule runs two sweeps: the first demotes the running thread and
  // counts ready ones, the second marks the pointer-th ready thread running.
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  rrtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // The result register parts the two sides: a finished beat waits there
  // while the controller goes back to accepting commands.
  rrtt_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (req_i.command),
    .thread_id_i  (req_i.thread_id),
    .owner_id_i   (req_i.owner_id),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .out_status_o (rsp_o.status),
    .out_thread_o (rsp_o.result_thread),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts)
  );

endmodule

>>> rtl/rrtt_checker.sv
// ----------------------------------------------------------------------------
// Round-robin thread table checker
// Port-level properties of the command and result channels.
// ----------------------------------------------------------------------------
module rrtt_checker import rrtt_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    req_valid_i,
  input logic    req_ready_i,
  input logic    rsp_valid_i,
  input logic    rsp_ready_i,
  input status_t rsp_status_i,
  input thread_t rsp_thread_i
);

  // Commands are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("command accepted in the cycle after another accept");

  // Every failure answers thread zero.
  a_fail_no_thread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != STATUS_OK) |-> rsp_thread_i == '0)
    else $error("failed command returned a thread id");

  // A new result appears only while the command side is busy.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("result beat appeared without a command in flight");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_thread_i))
    else $error("stalled result beat changed");

endmodule

bind round_robin_thread_table_top rrtt_checker u_rrtt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_thread_i (rsp_o.result_thread)
);

>>> tb/round_robin_thread_table_top_tb.sv
// ----------------------------------------------------------------------------
// Round-robin thread table testbench
// Drives commands into the thread table over the request channel and checks
// every answer on the response channel against a cycle-free software copy of
// the table that runs in step with the accepted commands. Directed cases come
// first, then a receiver hold-off and three random mixes, the table filled after the first.
// ----------------------------------------------------------------------------
module round_robin_thread_table_top_tb;
  import rrtt_pkg::*;

  localparam int unsigned TABLE_SLOTS = 32;
  localparam int unsigned HALF_PERIOD = 10;
  localparam int unsigned RESET_CYCLES = 9;
  // Schedule sweeps the table twice, which makes it the longest command.
  localparam int unsigned DRAIN_CYCLES = 100;
  // Long enough for the request side to fill up and stall behind one answer.
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_CYCLES = 700000;

  // Command codes six and seven are not decoded and must be answered as no-ops.
  localparam cmd_t CMD_SPARE_A = 3'd6;
  localparam cmd_t CMD_SPARE_B = 3'd7;

  typedef struct packed {
    status_t status;
    thread_t result_thread;
  } thread_answer_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rrtt_req_if req_bus ();
  rrtt_rsp_if rsp_bus ();

  round_robin_thread_table_top #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus.sink),
    .rsp_o (rsp_bus.source)
  );

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // Shadow copy of the thread table. Only slots below shadow_used are ever
  // read, exactly as in the block itself.
  slot_st_t    shadow_state [TABLE_SLOTS];
  owner_t      shadow_owner [TABLE_SLOTS];
  int unsigned shadow_used;
  int unsigned shadow_rr;

  thread_answer_t pending_answers [$];
  thread_answer_t oldest_answer;

  // Owners used by most creates, so that terminate-all hits a few threads.
  owner_t owner_pool [16] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                              16'h1234, 16'hABCD, 16'h5555, 16'hAAAA,
                              16'h00FF, 16'hFF00, 16'h7FFF, 16'h0F0F,
                              16'hF0F0, 16'h3C3C, 16'hC3C3, 16'h0100};

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;
  int hold_left;

  int fail_count;
  int beats_sent;
  int answers_checked;
  int status_seen [4];

  // Computes the answer to one accepted command and updates the shadow table.
  function automatic void predict_answer(cmd_t cmd, thread_t tid, owner_t owner);
    thread_answer_t ans;
    int slot;
    int unsigned ready_cnt;
    int unsigned seen;
    ans.status = STATUS_OK;
    ans.result_thread = '0;
    slot = (tid == 0 || tid > shadow_used) ? -1 : int'(tid) - 1;
    case (cmd)
      CMD_CREATE: begin
        if (shadow_used >= TABLE_SLOTS) begin
          ans.status = STATUS_FULL;
        end else begin
          shadow_state[shadow_used] = SLOT_READY;
          shadow_owner[shadow_used] = owner;
          shadow_used++;
          ans.result_thread = thread_t'(shadow_used);
        end
      end
      CMD_TERMINATE, CMD_BLOCK, CMD_UNBLOCK: begin
        if (slot < 0) begin
          ans.status = STATUS_NO_THREAD;
        end else if (cmd == CMD_TERMINATE) begin
          shadow_state[slot] = SLOT_TERMINATED;
        end else if (cmd == CMD_BLOCK) begin
          if (shadow_state[slot] == SLOT_READY || shadow_state[slot] == SLOT_RUNNING)
            shadow_state[slot] = SLOT_BLOCKED;
        end else if (shadow_state[slot] == SLOT_BLOCKED) begin
          shadow_state[slot] = SLOT_READY;
        end
      end
      CMD_TERM_ALL: begin
        for (int i = 0; i < shadow_used; i++)
          if (shadow_owner[i] == owner) shadow_state[i] = SLOT_TERMINATED;
      end
      CMD_SCHEDULE: begin
        ready_cnt = 0;
        seen = 0;
        for (int i = 0; i < shadow_used; i++)
          if (shadow_state[i] == SLOT_RUNNING) shadow_state[i] = SLOT_READY;
        for (int i = 0; i < shadow_used; i++)
          if (shadow_state[i] == SLOT_READY) ready_cnt++;
        if (ready_cnt == 0) begin
          ans.status = STATUS_IDLE;
        end else begin
          if (shadow_rr >= ready_cnt) shadow_rr = 0;
          for (int i = 0; i < shadow_used; i++) begin
            if (shadow_state[i] == SLOT_READY) begin
              if (seen == shadow_rr) begin
                shadow_state[i] = SLOT_RUNNING;
                ans.result_thread = thread_t'(i + 1);
                break;
              end
              seen++;
            end
          end
          shadow_rr = (shadow_rr + 1) % ready_cnt;
        end
      end
      default: ;
    endcase
    pending_answers.push_back(ans);
  endfunction

  // Offers one command beat. The task is entered right after the previous
  // beat was accepted (or after reset), so valid stays high between
  // back-to-back beats and is only lowered at a negedge where the sender idles.
  task automatic send_command(cmd_t cmd, thread_t tid, owner_t owner);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.command   <= cmd;
    req_bus.thread_id <= tid;
    req_bus.owner_id  <= owner;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    predict_answer(cmd, tid, owner);
    beats_sent++;
  endtask

  // Mostly a thread that exists, sometimes any id in range, zero included.
  function automatic thread_t random_target();
    if (shadow_used > 0 && $urandom_range(9) != 0)
      return thread_t'($urandom_range(shadow_used, 1));
    return thread_t'($urandom_range(TABLE_SLOTS, 0));
  endfunction

  // Receiver: random ready, or a counted hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every answer beat is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_answers.size() == 0) begin
        $error("answer beat with no command waiting: status %0d, result_thread %0d",
               rsp_bus.status, rsp_bus.result_thread);
        fail_count++;
      end else begin
        oldest_answer = pending_answers.pop_front();
        answers_checked++;
        status_seen[rsp_bus.status]++;
        if (rsp_bus.status !== oldest_answer.status) begin
          $error("status: expected %0d, actual %0d", oldest_answer.status, rsp_bus.status);
          fail_count++;
        end
        if (rsp_bus.result_thread !== oldest_answer.result_thread) begin
          $error("result_thread: expected %0d, actual %0d",
                 oldest_answer.result_thread, rsp_bus.result_thread);
          fail_count++;
        end
      end
    end
  end

  // Commands on an empty table: nothing runnable, unknown ids, empty sweeps.
  task automatic test_empty_table();
    send_command(CMD_SCHEDULE, '0, '0);
    send_command(CMD_TERMINATE, '0, '0);
    send_command(CMD_BLOCK, 6'd1, '0);
    send_command(CMD_UNBLOCK, 6'd32, 16'hFFFF);
    send_command(CMD_TERM_ALL, '0, 16'h0000);
    send_command(CMD_TERM_ALL, '0, 16'hFFFF);
  endtask

  // A few threads with the owner extremes, then the pointer wraps around.
  task automatic test_create_and_rotate();
    send_command(CMD_CREATE, '0, 16'h0000);
    send_command(CMD_CREATE, 6'd32, 16'hFFFF);
    send_command(CMD_CREATE, '0, 16'h1234);
    repeat (4) send_command(CMD_SCHEDULE, '0, '0);
  endtask

  // Block, unblock, terminate, terminate-all and a schedule, including the
  // no-change cases, id zero and an id just above the slots in use.
  task automatic test_state_changes();
    send_command(CMD_BLOCK, 6'd2, '0);
    send_command(CMD_BLOCK, 6'd2, '0);
    send_command(CMD_UNBLOCK, 6'd1, '0);
    send_command(CMD_UNBLOCK, 6'd2, '0);
    send_command(CMD_TERMINATE, 6'd3, '0);
    send_command(CMD_TERMINATE, 6'd3, '0);
    send_command(CMD_TERM_ALL, '0, 16'hFFFF);
    send_command(CMD_SCHEDULE, '0, '0);
    send_command(CMD_TERMINATE, 6'd4, '0);
    send_command(CMD_BLOCK, '0, 16'hFFFF);
  endtask

  // The two undecoded command codes with every field at an extreme.
  task automatic test_unused_codes();
    send_command(CMD_SPARE_A, 6'd32, 16'hFFFF);
    send_command(CMD_SPARE_B, '0, 16'h0000);
  endtask

  // Creates until the table is full, then a couple more that must bounce.
  task automatic test_full_table();
    while (shadow_used < TABLE_SLOTS)
      send_command(CMD_CREATE, random_target(), owner_pool[$urandom_range(15)]);
    repeat (2) send_command(CMD_CREATE, '0, owner_t'($urandom()));
  endtask

  // The receiver stops for a long while; the sender keeps offering beats,
  // so the block holds one answer in its result register and stalls the request side.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    repeat (12) begin
      if ($urandom_range(1) == 0) send_command(CMD_SCHEDULE, '0, '0);
      else send_command(CMD_BLOCK + cmd_t'($urandom_range(1)), random_target(), '0);
    end
  endtask

  // Random traffic weighted toward scheduling and block/unblock churn, with
  // terminations kept rare so that the table stays alive for most of the run.
  task automatic test_random_mix(int beats, int send_pct, int recv_pct);
    int pick;
    cmd_t cmd;
    thread_t tid;
    owner_t owner;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (beats) begin
      pick  = $urandom_range(999);
      tid   = random_target();
      owner = owner_pool[$urandom_range(15)];
      if (pick < 50) begin
        cmd = CMD_CREATE;
        if ($urandom_range(99) < 15) owner = owner_t'($urandom());
      end else if (pick < 65) begin
        cmd = CMD_TERMINATE;
      end else if (pick < 85) begin
        cmd = CMD_TERM_ALL;
        if ($urandom_range(99) >= 15) owner = owner_t'($urandom());
      end else if (pick < 300) begin
        cmd = CMD_BLOCK;
      end else if (pick < 530) begin
        cmd = CMD_UNBLOCK;
      end else if (pick < 990) begin
        cmd = CMD_SCHEDULE;
      end else begin
        // Noise: any code, any id in range, any owner.
        cmd   = cmd_t'($urandom_range(7));
        tid   = thread_t'($urandom_range(TABLE_SLOTS, 0));
        owner = owner_t'($urandom());
      end
      send_command(cmd, tid, owner);
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.command   = '0;
    req_bus.thread_id = '0;
    req_bus.owner_id  = '0;
    rsp_bus.ready     = 1'b0;
    shadow_used       = 0;
    shadow_rr         = 0;
    hold_request      = 1'b0;
    hold_left         = 0;
    fail_count        = 0;
    beats_sent        = 0;
    answers_checked   = 0;
    send_idle_pct     = 19;
    recv_idle_pct     = 52;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_create_and_rotate();
    test_state_changes();
    test_unused_codes();
    test_backpressure();
    test_random_mix(380, 19, 52);
    test_full_table();
    test_random_mix(380, 52, 19);
    test_random_mix(380, 0, 0);

    // Drop valid after the last accepted beat, then drain.
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d commands and checked %0d answers: %0d ok, %0d unknown id, %0d full, %0d idle.",
             beats_sent, answers_checked, status_seen[STATUS_OK],
             status_seen[STATUS_NO_THREAD], status_seen[STATUS_FULL], status_seen[STATUS_IDLE]);
    $display("Covered empty and full table, unused codes, a long receiver hold-off and three idle mixes.");
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(2 * HALF_PERIOD * WATCHDOG_CYCLES);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/rrtt_pkg.sv
rtl/rrtt_if.sv
rtl/rrtt_ctrl.sv
rtl/rrtt_dp.sv
rtl/round_robin_thread_table_top.sv
rtl/rrtt_checker.sv
tb/round_robin_thread_table_top_tb.sv
